@@ hdl/cle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the cursor line editor (gap buffer editor).
// ----------------------------------------------------------------------------
package cle_pkg;

   // Default number of characters the line can hold.
   localparam int LINE_DEPTH = 1024;

   // Fixed field widths of the item channels.
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 10;
   localparam int LEN_W   = 11;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_CODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_CODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELETE_CODE = 2'd2;

   // Reset values of the key codes: '<', '>' and '-'.
   localparam logic [BYTE_W-1:0] LEFT_CODE_RST   = 8'd60;
   localparam logic [BYTE_W-1:0] RIGHT_CODE_RST  = 8'd62;
   localparam logic [BYTE_W-1:0] DELETE_CODE_RST = 8'd45;

   // Item kinds.
   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef enum logic [2:0] {
      OP_LEFT,
      OP_RIGHT,
      OP_DELETE,
      OP_INSERT,
      OP_READ
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Write enables of the two stack memories.
   typedef struct packed {
      logic before_we;
      logic after_we;
   } mem_we_type;

endpackage

@@ hdl/cursor_line_editor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_line_editor_top
// One-line text editor with a cursor, kept as a gap buffer of two stacks.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Carries
//  req_      req_valid/req_ready    kind, key byte, read position
//  rsp_      rsp_valid/rsp_ready    cursor, length, dropped, read byte/valid
//  csr_      csr_we (no wait)       left, right and delete key codes
//
// For each item the accept cycle issues the stack memory read; the execute
// state then writes back, updates the counters and loads the result
// register. The next item is taken once the block is back in its idle state.
// A result that is not taken holds the block in its execute state.
// Reset is synchronous; it clears the counters and restores the key codes.
// No clearing pass: only stack entries that were written are used.
// ----------------------------------------------------------------------------
module cursor_line_editor_top #(
   parameter int LineDepth = cle_pkg::LINE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [cle_pkg::BYTE_W-1:0]    req_key_byte,
   input  logic [cle_pkg::POS_W-1:0]     req_read_pos,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cle_pkg::LEN_W-1:0]     rsp_cursor_pos,
   output logic [cle_pkg::LEN_W-1:0]     rsp_text_length,
   output logic                          rsp_dropped,
   output logic [cle_pkg::BYTE_W-1:0]    rsp_read_byte,
   output logic                          rsp_read_valid,
   input  logic                          csr_we,
   input  logic [cle_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cle_pkg::BYTE_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(LineDepth);

   cle_pkg::mem_we_type         mem_we;
   logic                        mem_re;
   logic [AW-1:0]               before_raddr, after_raddr;
   logic [AW-1:0]               before_waddr, after_waddr;
   logic [cle_pkg::BYTE_W-1:0]  before_wdata, after_wdata;
   logic [cle_pkg::BYTE_W-1:0]  before_rdata, after_rdata;

   cle_ctrl #(
      .LineDepth(LineDepth)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_key_byte   (req_key_byte),
      .req_read_pos   (req_read_pos),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_text_length(rsp_text_length),
      .rsp_dropped    (rsp_dropped),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_read_valid (rsp_read_valid),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mem_re         (mem_re),
      .mem_we         (mem_we),
      .before_raddr   (before_raddr),
      .after_raddr    (after_raddr),
      .before_waddr   (before_waddr),
      .after_waddr    (after_waddr),
      .before_wdata   (before_wdata),
      .after_wdata    (after_wdata),
      .before_rdata   (before_rdata),
      .after_rdata    (after_rdata)
   );

   // Text left of the cursor, top of stack next to the cursor.
   cle_ram #(
      .Width(cle_pkg::BYTE_W),
      .Depth(LineDepth)
   ) u_before_ram (
      .clock(clock),
      .we   (mem_we.before_we),
      .waddr(before_waddr),
      .wdata(before_wdata),
      .re   (mem_re),
      .raddr(before_raddr),
      .rdata(before_rdata)
   );

   // Text right of the cursor, top of stack next to the cursor.
   cle_ram #(
      .Width(cle_pkg::BYTE_W),
      .Depth(LineDepth)
   ) u_after_ram (
      .clock(clock),
      .we   (mem_we.after_we),
      .waddr(after_waddr),
      .wdata(after_wdata),
      .re   (mem_re),
      .raddr(after_raddr),
      .rdata(after_rdata)
   );

endmodule

@@ hdl/cle_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cle_ram #(
   parameter int Width = cle_pkg::BYTE_W,
   parameter int Depth = cle_pkg::LINE_DEPTH
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/cle_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ctrl
// Key decode, stack counters, memory sequencing and result register.
// ----------------------------------------------------------------------------
module cle_ctrl #(
   parameter int LineDepth = cle_pkg::LINE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [cle_pkg::BYTE_W-1:0]     req_key_byte,
   input  logic [cle_pkg::POS_W-1:0]      req_read_pos,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cle_pkg::LEN_W-1:0]      rsp_cursor_pos,
   output logic [cle_pkg::LEN_W-1:0]      rsp_text_length,
   output logic                           rsp_dropped,
   output logic [cle_pkg::BYTE_W-1:0]     rsp_read_byte,
   output logic                           rsp_read_valid,
   input  logic                           csr_we,
   input  logic [cle_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cle_pkg::BYTE_W-1:0]     csr_wdata,
   output logic                           mem_re,
   output cle_pkg::mem_we_type            mem_we,
   output logic [$clog2(LineDepth)-1:0]   before_raddr,
   output logic [$clog2(LineDepth)-1:0]   after_raddr,
   output logic [$clog2(LineDepth)-1:0]   before_waddr,
   output logic [$clog2(LineDepth)-1:0]   after_waddr,
   output logic [cle_pkg::BYTE_W-1:0]     before_wdata,
   output logic [cle_pkg::BYTE_W-1:0]     after_wdata,
   input  logic [cle_pkg::BYTE_W-1:0]     before_rdata,
   input  logic [cle_pkg::BYTE_W-1:0]     after_rdata
);

   localparam int AW = $clog2(LineDepth);
   localparam int CW = $clog2(LineDepth + 1);
   localparam int SW = ((CW > cle_pkg::POS_W) ? CW : cle_pkg::POS_W) + 1;
   localparam int LW = cle_pkg::LEN_W;
   localparam int BW = cle_pkg::BYTE_W;

   cle_pkg::state_type state_ff, state_in;
   cle_pkg::op_type    op_ff, op_in;
   logic               act_ff, act_in;
   logic               sel_after_ff, sel_after_in;
   logic [BW-1:0]      key_ff;
   logic [CW-1:0]      before_count_ff, before_count_in;
   logic [CW-1:0]      after_count_ff, after_count_in;
   logic [BW-1:0]      left_code_ff, right_code_ff, delete_code_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]      cursor_ff, cursor_in;
   logic [LW-1:0]      length_ff, length_in;
   logic               dropped_ff, dropped_in;
   logic [BW-1:0]      rbyte_ff, rbyte_in;
   logic               rvalid_ff, rvalid_in;

   logic               accept;
   logic               finish;
   logic [SW-1:0]      len_now;
   logic [SW-1:0]      pos_wide;

   assign accept   = req_valid && req_ready;
   assign len_now  = SW'(before_count_ff) + SW'(after_count_ff);
   assign pos_wide = SW'(req_read_pos);

   // Decode of the incoming item against the counters as they stand now.
   always_comb begin
      if (req_kind == cle_pkg::KIND_READ) begin
         op_in = cle_pkg::OP_READ;
      end else if (req_key_byte == left_code_ff) begin
         op_in = cle_pkg::OP_LEFT;
      end else if (req_key_byte == right_code_ff) begin
         op_in = cle_pkg::OP_RIGHT;
      end else if (req_key_byte == delete_code_ff) begin
         op_in = cle_pkg::OP_DELETE;
      end else begin
         op_in = cle_pkg::OP_INSERT;
      end

      unique case (op_in)
         cle_pkg::OP_LEFT: begin
            act_in = (before_count_ff != '0) && (SW'(after_count_ff) < SW'(LineDepth));
         end
         cle_pkg::OP_RIGHT: begin
            act_in = (after_count_ff != '0) && (SW'(before_count_ff) < SW'(LineDepth));
         end
         cle_pkg::OP_DELETE: begin
            act_in = (before_count_ff != '0);
         end
         cle_pkg::OP_INSERT: begin
            act_in = (len_now < SW'(LineDepth));
         end
         default: begin
            act_in = (pos_wide < len_now);
         end
      endcase

      sel_after_in = (pos_wide >= SW'(before_count_ff));

      // A read item addresses the stack that holds the position; the after
      // stack holds the line's end at its bottom, so its entry is counted from the far end.
      if (op_in == cle_pkg::OP_READ) begin
         before_raddr = AW'(req_read_pos);
         after_raddr  = AW'(len_now - SW'(1) - pos_wide);
      end else begin
         before_raddr = AW'(before_count_ff - CW'(1));
         after_raddr  = AW'(after_count_ff - CW'(1));
      end
   end

   assign mem_re = accept;

   // State machine, stack updates and result register loading.
   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      finish          = 1'b0;
      before_count_in = before_count_ff;
      after_count_in  = after_count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         cle_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = cle_pkg::ST_EXEC;
            end
         end
         cle_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               finish   = 1'b1;
               state_in = cle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cle_pkg::ST_IDLE;
         end
      endcase

      if (finish && act_ff) begin
         case (op_ff)
            cle_pkg::OP_LEFT: begin
               before_count_in = before_count_ff - CW'(1);
               after_count_in  = after_count_ff + CW'(1);
            end
            cle_pkg::OP_RIGHT: begin
               before_count_in = before_count_ff + CW'(1);
               after_count_in  = after_count_ff - CW'(1);
            end
            cle_pkg::OP_DELETE: begin
               before_count_in = before_count_ff - CW'(1);
            end
            cle_pkg::OP_INSERT: begin
               before_count_in = before_count_ff + CW'(1);
            end
            default: begin
               before_count_in = before_count_ff;
            end
         endcase
      end

      mem_we.before_we = finish && act_ff &&
                         (op_ff == cle_pkg::OP_RIGHT || op_ff == cle_pkg::OP_INSERT);
      mem_we.after_we  = finish && act_ff && (op_ff == cle_pkg::OP_LEFT);

      cursor_in  = LW'(before_count_in);
      length_in  = LW'(SW'(before_count_in) + SW'(after_count_in));
      dropped_in = (op_ff == cle_pkg::OP_INSERT) && !act_ff;
      rvalid_in  = (op_ff == cle_pkg::OP_READ) && act_ff;
      if (rvalid_in) begin
         rbyte_in = sel_after_ff ? after_rdata : before_rdata;
      end else begin
         rbyte_in = '0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign before_waddr = AW'(before_count_ff);
   assign after_waddr  = AW'(after_count_ff);
   assign before_wdata = (op_ff == cle_pkg::OP_INSERT) ? key_ff : after_rdata;
   assign after_wdata  = before_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= cle_pkg::ST_IDLE;
         before_count_ff <= '0;
         after_count_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
         left_code_ff    <= cle_pkg::LEFT_CODE_RST;
         right_code_ff   <= cle_pkg::RIGHT_CODE_RST;
         delete_code_ff  <= cle_pkg::DELETE_CODE_RST;
      end else begin
         state_ff        <= state_in;
         before_count_ff <= before_count_in;
         after_count_ff  <= after_count_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               cle_pkg::CSR_LEFT_CODE:   left_code_ff   <= csr_wdata;
               cle_pkg::CSR_RIGHT_CODE:  right_code_ff  <= csr_wdata;
               cle_pkg::CSR_DELETE_CODE: delete_code_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= op_in;
         act_ff       <= act_in;
         sel_after_ff <= sel_after_in;
         key_ff       <= req_key_byte;
      end
      if (finish) begin
         cursor_ff  <= cursor_in;
         length_ff  <= length_in;
         dropped_ff <= dropped_in;
         rbyte_ff   <= rbyte_in;
         rvalid_ff  <= rvalid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cursor_pos  = cursor_ff;
   assign rsp_text_length = length_ff;
   assign rsp_dropped     = dropped_ff;
   assign rsp_read_byte   = rbyte_ff;
   assign rsp_read_valid  = rvalid_ff;

endmodule

@@ hdl/cle_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks of the cursor line editor, bound to the top level.
// ----------------------------------------------------------------------------
module cle_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cle_pkg::LEN_W-1:0]     rsp_cursor_pos,
   input logic [cle_pkg::LEN_W-1:0]     rsp_text_length,
   input logic                          rsp_dropped,
   input logic [cle_pkg::BYTE_W-1:0]    rsp_read_byte,
   input logic                          rsp_read_valid
);

   // An insert that was refused never reports a read.
   a_dropped_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> !rsp_read_valid && rsp_read_byte == '0)
      else $error("dropped item reports a read");

   // Without a valid read the byte field is zero.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_read_byte == '0)
      else $error("read byte set without a valid read");

   // One item at a time: after an accept the input side is closed.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in progress");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_pos)
         && $stable(rsp_text_length) && $stable(rsp_read_byte))
      else $error("stalled result changed");

endmodule

bind cursor_line_editor_top cle_checker u_cle_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cursor_pos (rsp_cursor_pos),
   .rsp_text_length(rsp_text_length),
   .rsp_dropped    (rsp_dropped),
   .rsp_read_byte  (rsp_read_byte),
   .rsp_read_valid (rsp_read_valid)
);
